/* design/fixed_point_alu_unit_defines.svh */
// assertion macros shared by the checker of the fixed-point alu
// no dependencies; included by files that hold concurrent assertions
`ifndef FIXED_POINT_ALU_UNIT_DEFINES_SVH
`define FIXED_POINT_ALU_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define FPALU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpalu assertion failed");

// next-cycle implication, off during reset
`define FPALU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpalu assertion failed");

`endif

/* design/fpalu_pkg.sv */
// types, codes and constants of the fixed-point alu
// no dependencies; imported by every module of the block but the checker
`timescale 1ns / 1ps
`default_nettype none

package fpalu_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int OP_W          = 32;
  localparam int KIND_W        = 4;
  localparam int IN_W          = 64;
  localparam int OUT_W         = 40;

  localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN32 = 32'h8000_0000;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD      = 4'd0,
    KIND_SUB      = 4'd1,
    KIND_MUL      = 4'd2,
    KIND_DIV      = 4'd3,
    KIND_MIN      = 4'd4,
    KIND_MAX      = 4'd5,
    KIND_INC      = 4'd6,
    KIND_DEC      = 4'd7,
    KIND_FROM_INT = 4'd8,
    KIND_TO_INT   = 4'd9
  } kind_t;

  // request payload carried down the cell chain
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              less;
    logic              equal;
    logic              greater;
    logic [31:0]       simple;
    logic              simple_ovf;
    logic              dz;
    logic              neg;
    logic [63:0]       prod;
    logic [31:0]       dvsr;
  } item_t;

endpackage

`default_nettype wire

/* design/fpalu_prep.sv */
// entry stage: operand decode, compare, simple ops and the 32x32 magnitude product
// depends on fpalu_pkg
`timescale 1ns / 1ps
`default_nettype none

module fpalu_prep #(
  parameter int FRAC_BITS = fpalu_pkg::FRAC_BITS_DEF,
  parameter int NW        = 32 + FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [3:0]           in_kind,
  input  logic [31:0]          in_a,
  input  logic [31:0]          in_b,
  output logic                 valid,
  input  logic                 ready,
  output fpalu_pkg::item_t     item,
  output logic [31:0]          rem,
  output logic [NW-1:0]        nq
);
  import fpalu_pkg::*;

  logic signed [31:0] a_s, b_s, a_top;
  logic [31:0]        mag_a, mag_b;
  logic signed [32:0] opb, sum;
  logic [31:0]        simple;
  logic               simple_ovf;
  logic               fi_ovf;
  item_t              item_next;

  assign a_s   = $signed(in_a);
  assign b_s   = $signed(in_b);
  assign mag_a = a_s[31] ? 32'(-in_a) : in_a;
  assign mag_b = b_s[31] ? 32'(-in_b) : in_b;
  assign a_top = a_s >>> (31 - FRAC_BITS);
  assign fi_ovf = !((a_top == 32'sd0) || (a_top == -32'sd1));

  // second addend of the shared adder
  always_comb begin
    case (kind_t'(in_kind))
      KIND_SUB: opb = -{b_s[31], b_s};
      KIND_INC: opb = 33'sd1;
      KIND_DEC: opb = -33'sd1;
      default:  opb = {b_s[31], b_s};
    endcase
  end
  assign sum = {a_s[31], a_s} + opb;

  // results that need no rounding
  always_comb begin
    simple     = '0;
    simple_ovf = 1'b0;
    unique case (kind_t'(in_kind))
      KIND_ADD, KIND_SUB, KIND_INC, KIND_DEC: begin
        if (sum[32] != sum[31]) begin
          simple_ovf = 1'b1;
          simple     = sum[32] ? MIN32 : MAX32;
        end else begin
          simple = sum[31:0];
        end
      end
      KIND_DIV: simple = a_s[31] ? MIN32 : MAX32;
      KIND_MIN: simple = (a_s < b_s) ? in_a : in_b;
      KIND_MAX: simple = (a_s > b_s) ? in_a : in_b;
      KIND_FROM_INT: begin
        simple_ovf = fi_ovf;
        simple     = fi_ovf ? (a_s[31] ? MIN32 : MAX32) : (in_a << FRAC_BITS);
      end
      KIND_TO_INT: simple = 32'(a_s >>> FRAC_BITS);
      default: simple = '0;
    endcase
  end

  always_comb begin
    item_next.kind       = in_kind;
    item_next.less       = a_s < b_s;
    item_next.equal      = in_a == in_b;
    item_next.greater    = a_s > b_s;
    item_next.simple     = simple;
    item_next.simple_ovf = simple_ovf;
    item_next.dz         = (kind_t'(in_kind) == KIND_DIV) && (in_b == 32'd0);
    item_next.neg        = a_s[31] ^ b_s[31];
    item_next.prod       = 64'(mag_a) * 64'(mag_b);
    item_next.dvsr       = mag_b;
  end

  assign in_ready = !valid || ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
      rem  <= '0;
      nq   <= NW'(mag_a) << FRAC_BITS;
    end
  end

endmodule

`default_nettype wire

/* design/fpalu_div_cell.sv */
// one cell of the divider chain: one restoring quotient bit per cell
// depends on fpalu_pkg
`timescale 1ns / 1ps
`default_nettype none

module fpalu_div_cell #(
  parameter int NW = 32 + fpalu_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  fpalu_pkg::item_t in_item,
  input  logic [31:0]      in_rem,
  input  logic [NW-1:0]    in_nq,
  output logic             valid,
  input  logic             ready,
  output fpalu_pkg::item_t item,
  output logic [31:0]      rem,
  output logic [NW-1:0]    nq
);
  import fpalu_pkg::*;

  logic [32:0] trial;
  logic        ge;
  logic [32:0] diff;

  // bring down the next numerator bit and try the subtract
  assign trial = {in_rem, in_nq[NW-1]};
  assign ge    = trial >= {1'b0, in_item.dvsr};
  assign diff  = trial - {1'b0, in_item.dvsr};

  assign in_ready = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
      rem  <= ge ? diff[31:0] : trial[31:0];
      nq   <= {in_nq[NW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

/* design/fpalu_final.sv */
// output stage: rounding and saturation of product and quotient, result select
// depends on fpalu_pkg
`timescale 1ns / 1ps
`default_nettype none

module fpalu_final #(
  parameter int FRAC_BITS = fpalu_pkg::FRAC_BITS_DEF,
  parameter int NW        = 32 + FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fpalu_pkg::item_t              in_item,
  input  logic [31:0]                   in_rem,
  input  logic [NW-1:0]                 in_nq,
  output logic                          valid,
  input  logic                          ready,
  output logic [fpalu_pkg::OUT_W-1:0]   data
);
  import fpalu_pkg::*;

  logic [63:0] q_mul, q_div, q;
  logic        round_up;
  logic        sat_ovf;
  logic [31:0] sat_res;
  logic [31:0] result;
  logic        ovf;
  logic        use_sat;

  // product rounded half away from zero on the magnitude
  assign q_mul = (in_item.prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  // quotient rounded up when twice the remainder reaches the divisor
  assign round_up = {in_rem, 1'b0} >= {1'b0, in_item.dvsr};
  assign q_div    = 64'(in_nq) + 64'(round_up);
  assign q = (kind_t'(in_item.kind) == KIND_MUL) ? q_mul : q_div;

  // sign and magnitude to 32 bits with saturation
  always_comb begin
    if (in_item.neg) begin
      sat_ovf = q > 64'h0000_0000_8000_0000;
      sat_res = sat_ovf ? MIN32 : 32'(-q[31:0]);
    end else begin
      sat_ovf = q > 64'h0000_0000_7FFF_FFFF;
      sat_res = sat_ovf ? MAX32 : q[31:0];
    end
  end

  assign use_sat = (kind_t'(in_item.kind) == KIND_MUL) ||
                   ((kind_t'(in_item.kind) == KIND_DIV) && !in_item.dz);
  assign result  = use_sat ? sat_res : in_item.simple;
  assign ovf     = use_sat ? sat_ovf : in_item.simple_ovf;

  assign in_ready = !valid || ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= {3'b000, in_item.dz, ovf, in_item.greater, in_item.equal, in_item.less, result};
    end
  end

endmodule

`default_nettype wire

/* design/fixed_point_alu_unit.sv */
// top level of the fixed-point alu: entry stage, divider cell chain, output stage
// depends on fpalu_pkg, fpalu_prep, fpalu_div_cell, fpalu_final
//
// channel | direction | tdata                        | tuser
// s       | in        | operand_a, operand_b         | kind
// m       | out       | result, less, equal, greater,| none
//         |           | overflow, divide_by_zero     |
//
// one request per cycle while the output is not stalled; the path is the entry stage,
// one divider cell per quotient bit, 32 + FRAC_BITS of them, and the output stage
// every stage is a register with its own valid; a stalled output only
// holds stages that are full, so bubbles close up and requests keep entering until every stage is full
// synchronous active-high reset clears all valid bits
`timescale 1ns / 1ps
`default_nettype none

module fixed_point_alu_unit #(
  parameter int FRAC_BITS = fpalu_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
  input  logic [3:0]  s_tuser,   // kind [3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // result [31:0], less, equal, greater, overflow,
                                 // divide_by_zero [36:32], zero fill
);
  import fpalu_pkg::*;

  localparam int NW = 32 + FRAC_BITS;

  logic            v   [0:NW];
  logic            rdy [0:NW];
  item_t           it  [0:NW];
  logic [31:0]     rm  [0:NW];
  logic [NW-1:0]   nq  [0:NW];

  // entry stage
  fpalu_prep #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_prep (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .in_kind(s_tuser), .in_a(s_tdata[31:0]), .in_b(s_tdata[63:32]),
    .valid(v[0]), .ready(rdy[0]), .item(it[0]), .rem(rm[0]), .nq(nq[0])
  );

  // divider chain, one quotient bit per cell
  for (genvar i = 0; i < NW; i++) begin : g_cell
    fpalu_div_cell #(.NW(NW)) u_cell (
      .clk(clk), .rst(rst),
      .in_valid(v[i]), .in_ready(rdy[i]),
      .in_item(it[i]), .in_rem(rm[i]), .in_nq(nq[i]),
      .valid(v[i+1]), .ready(rdy[i+1]),
      .item(it[i+1]), .rem(rm[i+1]), .nq(nq[i+1])
    );
  end

  // rounding, saturation and output register
  fpalu_final #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_final (
    .clk(clk), .rst(rst),
    .in_valid(v[NW]), .in_ready(rdy[NW]),
    .in_item(it[NW]), .in_rem(rm[NW]), .in_nq(nq[NW]),
    .valid(m_tvalid), .ready(m_tready), .data(m_tdata)
  );

endmodule

`default_nettype wire

/* design/fpalu_checker.sv */
// port-level checker of the fixed-point alu and its bind to the top level
// depends on fixed_point_alu_unit_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_point_alu_unit_defines.svh"

module fpalu_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // a result waiting at the output stays offered
  `FPALU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

  // exactly one compare flag per result
  `FPALU_ASSERT_NOW(a_cmp_onehot, m_tvalid, $onehot(m_tdata[34:32]))

  // divide by zero never reports saturation as well
  `FPALU_ASSERT_NOW(a_dz_no_ovf, m_tvalid, !(m_tdata[35] && m_tdata[36]))

  // zero fill above the flags
  `FPALU_ASSERT_NOW(a_fill_zero, m_tvalid, m_tdata[39:37] == 3'b000)

endmodule

bind fixed_point_alu_unit fpalu_checker u_fpalu_checker (.*);

`default_nettype wire
